FILE: src/hybrid_merge_insertion_sorter_assert.svh
// Assertion macros for the hybrid merge/insertion sorter checker.
// Self-contained; expects a clock and an active-low reset name as arguments.
`ifndef HYBRID_MERGE_INSERTION_SORTER_ASSERT_SVH
`define HYBRID_MERGE_INSERTION_SORTER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define HMS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define HMS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/hms_pkg.sv
// Shared constants, types and helpers of the hybrid merge/insertion sorter.
// No dependencies; used by the top level, hms_front, hms_fifo and hms_back.
package hms_pkg;

	localparam int DATA_W     = 32;
	localparam int MAX_ITEMS  = 64;
	localparam int ADDR_W     = $clog2(MAX_ITEMS);
	localparam int CNT_W      = $clog2(MAX_ITEMS + 1);
	localparam int IDX_W      = CNT_W + 1;
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

	// One classified beat travelling from the front to the back.
	typedef struct packed {
		logic [DATA_W-1:0] value;
		logic              last;
		logic              drop;
	} hms_entry_t;

	// Head of the queue as the back sees it.
	typedef struct packed {
		logic       valid;
		hms_entry_t entry;
	} hms_q_t;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_SETUP,
		ST_FETCH_A,
		ST_FETCH_B,
		ST_PICK,
		ST_FETCH,
		ST_OUT_RD,
		ST_OUT_WR
	} hms_state_t;

	// Two's complement less-than.
	function automatic logic hms_less(input logic [DATA_W-1:0] a, input logic [DATA_W-1:0] b);
		return $signed(a) < $signed(b);
	endfunction

endpackage

FILE: src/hybrid_merge_insertion_sorter.sv
// Sorts a batch of signed 32-bit values, given one per input beat with the final beat marked by
// last_item, and returns them in ascending order with last_out on the final result. Up to 64
// values are kept; further beats of the batch are dropped and overflow is set on every result of
// that batch. Input beats are taken one per cycle into a four-entry queue while it has room,
// and stored one per cycle while the back end is loading. Once the final beat is stored, a
// bottom-up merge sort runs between two 64-entry RAMs in ceil(log2 N) passes; each merged
// value needs one registered read of the source RAM. Results are then read from the RAM and
// streamed out through an output register, the next read only after the last result is loaded.
// While a batch is sorted or emitted, beats of the next batch fill the queue and then see stall.
// Depends on hms_pkg, hms_front, hms_fifo and hms_back.
module hybrid_merge_insertion_sorter (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] value,
	input  logic               last_item,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] sorted_value,
	output logic               last_out,
	output logic               overflow
);

	logic                       q_full;
	logic                       push;
	hms_pkg::hms_entry_t        push_entry;
	logic                       pop;
	hms_pkg::hms_q_t            q_head;
	logic [hms_pkg::DATA_W-1:0] out_value;

	hms_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.value      (value),
		.last_item  (last_item),
		.q_full     (q_full),
		.push       (push),
		.push_entry (push_entry)
	);

	hms_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (q_full),
		.pop        (pop),
		.head       (q_head)
	);

	hms_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (q_head),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_value (out_value),
		.out_last  (last_out),
		.out_ovf   (overflow)
	);

	assign sorted_value = $signed(out_value);

endmodule

FILE: src/hms_ram.sv
// Generic single-write, single-read RAM with registered, enabled read.
// No dependencies.
module hms_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read port; data holds while re is low
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: src/hms_front.sv
// Front end: accepts input beats and marks those beyond the store depth.
// Depends on hms_pkg.
module hms_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [hms_pkg::DATA_W-1:0] value,
	input  logic                      last_item,
	input  logic                      q_full,
	output logic                      push,
	output hms_pkg::hms_entry_t       push_entry
);

	logic [hms_pkg::CNT_W-1:0] cnt_q;
	logic                      drop;

	// Stall only when the queue has no room
	assign in_stall = q_full;
	assign push     = in_valid && !q_full;
	assign drop     = (cnt_q == hms_pkg::CNT_W'(hms_pkg::MAX_ITEMS));

	always_comb begin
		push_entry.value = value;
		push_entry.last  = last_item;
		push_entry.drop  = drop;
	end

	// Count beats of the current batch, saturating at the store depth
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (push) begin
			if (last_item) begin
				cnt_q <= '0;
			end else if (!drop) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

endmodule

FILE: src/hms_fifo.sv
// Short queue between front and back so each side stalls on its own.
// Depends on hms_pkg.
module hms_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  hms_pkg::hms_entry_t push_entry,
	output logic                full,
	input  logic                pop,
	output hms_pkg::hms_q_t     head
);

	hms_pkg::hms_entry_t            mem_q [hms_pkg::FIFO_DEPTH];
	logic [hms_pkg::FIFO_PTR_W-1:0] wr_ptr_q;
	logic [hms_pkg::FIFO_PTR_W-1:0] rd_ptr_q;
	logic [hms_pkg::FIFO_CNT_W-1:0] cnt_q;
	logic                           do_push;
	logic                           do_pop;

	assign full       = (cnt_q == hms_pkg::FIFO_CNT_W'(hms_pkg::FIFO_DEPTH));
	assign do_push    = push && !full;
	assign do_pop     = pop && (cnt_q != '0);
	assign head.valid = (cnt_q != '0);
	assign head.entry = mem_q[rd_ptr_q];

	// Store entries
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == hms_pkg::FIFO_PTR_W'(hms_pkg::FIFO_DEPTH - 1)) ?
				            '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == hms_pkg::FIFO_PTR_W'(hms_pkg::FIFO_DEPTH - 1)) ?
				            '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!do_push && do_pop) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

FILE: src/hms_back.sv
// Back end: stores a batch, merge-sorts it bottom-up between two RAMs, streams it out.
// Depends on hms_pkg and hms_ram.
module hms_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  hms_pkg::hms_q_t            head,
	output logic                       pop,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [hms_pkg::DATA_W-1:0] out_value,
	output logic                       out_last,
	output logic                       out_ovf
);

	localparam int DW = hms_pkg::DATA_W;
	localparam int AW = hms_pkg::ADDR_W;
	localparam int CW = hms_pkg::CNT_W;
	localparam int IW = hms_pkg::IDX_W;

	hms_pkg::hms_state_t st_q, st_d;

	logic [CW-1:0] cnt_q;
	logic          ovf_q;
	logic [CW-1:0] n_q;
	logic [IW-1:0] n_ext;
	logic [IW-1:0] w_q, base_q, ia_q, ae_q, ib_q, be_q, k_q;
	logic [DW-1:0] head_a_q, head_b_q;
	logic          take_a_q;
	logic          src_b_q;
	logic          out_valid_q;
	logic [DW-1:0] out_value_q;
	logic          out_last_q;
	logic          out_ovf_q;

	logic [CW-1:0] n_load;
	logic          a_ok, b_ok, take_a;
	logic [IW-1:0] sum_a, sum_b, end_a, end_b, next_base, w2;
	logic          load_we, merge_we, rd_en, out_load;
	logic [AW-1:0] rd_addr;
	logic [DW-1:0] merge_wdata;
	logic [DW-1:0] rd_a, rd_b, rdata;
	logic          we_a, we_b;
	logic [AW-1:0] waddr_a;
	logic [DW-1:0] wdata_a;

	// Merge compare and run bounds
	assign n_load    = cnt_q + CW'(!head.entry.drop);
	assign n_ext     = {1'b0, n_q};
	assign a_ok      = (ia_q < ae_q);
	assign b_ok      = (ib_q < be_q);
	assign take_a    = a_ok && (!b_ok || !hms_pkg::hms_less(head_b_q, head_a_q));
	assign w2        = w_q << 1;
	assign sum_a     = base_q + w_q;
	assign sum_b     = base_q + w2;
	assign end_a     = (sum_a < n_ext) ? sum_a : n_ext;
	assign end_b     = (sum_b < n_ext) ? sum_b : n_ext;
	assign next_base = sum_b;
	assign out_load  = (st_q == hms_pkg::ST_OUT_WR) && (!out_valid_q || !out_stall);
	assign rdata     = src_b_q ? rd_b : rd_a;

	// Next state
	always_comb begin
		st_d = st_q;
		case (st_q)
			hms_pkg::ST_LOAD: begin
				if (head.valid && head.entry.last) begin
					st_d = (n_load <= CW'(1)) ? hms_pkg::ST_OUT_RD : hms_pkg::ST_SETUP;
				end
			end
			hms_pkg::ST_SETUP:   st_d = hms_pkg::ST_FETCH_A;
			hms_pkg::ST_FETCH_A: st_d = hms_pkg::ST_FETCH_B;
			hms_pkg::ST_FETCH_B: st_d = hms_pkg::ST_PICK;
			hms_pkg::ST_PICK: begin
				if (a_ok || b_ok) begin
					st_d = hms_pkg::ST_FETCH;
				end else if (next_base >= n_ext && w2 >= n_ext) begin
					st_d = hms_pkg::ST_OUT_RD;
				end else begin
					st_d = hms_pkg::ST_SETUP;
				end
			end
			hms_pkg::ST_FETCH:  st_d = hms_pkg::ST_PICK;
			hms_pkg::ST_OUT_RD: begin
				st_d = (k_q == n_ext) ? hms_pkg::ST_LOAD : hms_pkg::ST_OUT_WR;
			end
			hms_pkg::ST_OUT_WR: begin
				if (out_load) begin
					st_d = hms_pkg::ST_OUT_RD;
				end
			end
			default: st_d = hms_pkg::ST_LOAD;
		endcase
	end

	// Queue pop and RAM controls
	always_comb begin
		pop         = 1'b0;
		load_we     = 1'b0;
		merge_we    = 1'b0;
		rd_en       = 1'b0;
		rd_addr     = ia_q[AW-1:0];
		merge_wdata = take_a ? head_a_q : head_b_q;
		case (st_q)
			hms_pkg::ST_LOAD: begin
				pop     = head.valid;
				load_we = head.valid && !head.entry.drop;
			end
			hms_pkg::ST_SETUP: begin
				rd_en   = 1'b1;
				rd_addr = base_q[AW-1:0];
			end
			hms_pkg::ST_FETCH_A: begin
				rd_en   = 1'b1;
				rd_addr = ib_q[AW-1:0];
			end
			hms_pkg::ST_PICK: begin
				merge_we = a_ok || b_ok;
				rd_en    = a_ok || b_ok;
				rd_addr  = take_a ? AW'(ia_q + 1'b1) : AW'(ib_q + 1'b1);
			end
			hms_pkg::ST_OUT_RD: begin
				rd_en   = (k_q != n_ext);
				rd_addr = k_q[AW-1:0];
			end
			default: begin
			end
		endcase
	end

	// Destination is the RAM that is not the source; loading always fills RAM A
	assign we_a    = load_we || (merge_we && src_b_q);
	assign we_b    = merge_we && !src_b_q;
	assign waddr_a = load_we ? cnt_q[AW-1:0] : k_q[AW-1:0];
	assign wdata_a = load_we ? head.entry.value : merge_wdata;

	hms_ram #(.WIDTH(DW), .DEPTH(hms_pkg::MAX_ITEMS)) u_ram_a (
		.clk   (clk),
		.we    (we_a),
		.waddr (waddr_a),
		.wdata (wdata_a),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_a)
	);

	hms_ram #(.WIDTH(DW), .DEPTH(hms_pkg::MAX_ITEMS)) u_ram_b (
		.clk   (clk),
		.we    (we_b),
		.waddr (k_q[AW-1:0]),
		.wdata (merge_wdata),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_b)
	);

	// Control registers: state, batch count, pass and run bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= hms_pkg::ST_LOAD;
			cnt_q       <= '0;
			ovf_q       <= 1'b0;
			n_q         <= '0;
			w_q         <= '0;
			base_q      <= '0;
			ia_q        <= '0;
			ae_q        <= '0;
			ib_q        <= '0;
			be_q        <= '0;
			k_q         <= '0;
			take_a_q    <= 1'b0;
			src_b_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			st_q <= st_d;
			case (st_q)
				hms_pkg::ST_LOAD: begin
					if (load_we) begin
						cnt_q <= cnt_q + 1'b1;
					end
					if (pop && head.entry.drop) begin
						ovf_q <= 1'b1;
					end
					if (pop && head.entry.last) begin
						n_q     <= n_load;
						w_q     <= IW'(1);
						base_q  <= '0;
						k_q     <= '0;
						src_b_q <= 1'b0;
					end
				end
				hms_pkg::ST_SETUP: begin
					ia_q <= base_q;
					ae_q <= end_a;
					ib_q <= end_a;
					be_q <= end_b;
				end
				hms_pkg::ST_PICK: begin
					if (a_ok || b_ok) begin
						k_q      <= k_q + 1'b1;
						take_a_q <= take_a;
						if (take_a) begin
							ia_q <= ia_q + 1'b1;
						end else begin
							ib_q <= ib_q + 1'b1;
						end
					end else if (next_base >= n_ext) begin
						// Pass done: double the run width and swap RAM roles
						w_q     <= w2;
						base_q  <= '0;
						k_q     <= '0;
						src_b_q <= !src_b_q;
					end else begin
						base_q <= next_base;
					end
				end
				hms_pkg::ST_OUT_RD: begin
					if (k_q == n_ext) begin
						cnt_q <= '0;
						ovf_q <= 1'b0;
					end
				end
				hms_pkg::ST_OUT_WR: begin
					if (out_load) begin
						k_q <= k_q + 1'b1;
					end
				end
				default: begin
				end
			endcase
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Run heads and output payload
	always_ff @(posedge clk) begin
		if (st_q == hms_pkg::ST_FETCH_A || (st_q == hms_pkg::ST_FETCH && take_a_q)) begin
			head_a_q <= rdata;
		end
		if (st_q == hms_pkg::ST_FETCH_B || (st_q == hms_pkg::ST_FETCH && !take_a_q)) begin
			head_b_q <= rdata;
		end
		if (out_load) begin
			out_value_q <= rdata;
			out_last_q  <= (k_q + 1'b1 == n_ext);
			out_ovf_q   <= ovf_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_value = out_value_q;
	assign out_last  = out_last_q;
	assign out_ovf   = out_ovf_q;

endmodule

FILE: src/hms_checker.sv
// Port-level checker for the sorter, attached to the top level by bind.
// Depends on hybrid_merge_insertion_sorter_assert.svh.
`include "hybrid_merge_insertion_sorter_assert.svh"

module hms_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic signed [31:0] value,
	input logic               last_item,
	input logic               out_valid,
	input logic               out_stall,
	input logic signed [31:0] sorted_value,
	input logic               last_out,
	input logic               overflow
);

	logic               out_beat;
	logic               prev_vld_q;
	logic signed [31:0] prev_val_q;
	logic               prev_ovf_q;

	assign out_beat = out_valid && !out_stall;

	// Remember the previous result beat of the current batch
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_vld_q <= 1'b0;
			prev_val_q <= '0;
			prev_ovf_q <= 1'b0;
		end else if (out_beat) begin
			prev_vld_q <= !last_out;
			prev_val_q <= sorted_value;
			prev_ovf_q <= overflow;
		end
	end

	`HMS_ASSERT_NEXT(a_in_beat_holds, clk, arst_n, in_valid && in_stall, in_valid && $stable(value) && $stable(last_item), "input beat changed while stalled")
	`HMS_ASSERT_NEXT(a_out_valid_holds, clk, arst_n, out_valid && out_stall, out_valid, "out_valid dropped while stalled")
	`HMS_ASSERT_NEXT(a_out_payload_holds, clk, arst_n, out_valid && out_stall, $stable(sorted_value) && $stable(last_out) && $stable(overflow), "result payload changed while stalled")
	`HMS_ASSERT_NOW(a_ascending, clk, arst_n, out_beat && prev_vld_q, sorted_value >= prev_val_q, "results not in ascending order")
	`HMS_ASSERT_NOW(a_overflow_steady, clk, arst_n, out_beat && prev_vld_q, overflow == prev_ovf_q, "overflow changed within a batch")

endmodule

bind hybrid_merge_insertion_sorter hms_checker u_hms_checker (.*);

FILE: test/hybrid_merge_insertion_sorter_test.sv
// Self-checking testbench for hybrid_merge_insertion_sorter: random batches with idle gaps and stalls.
// Depends on hms_pkg and the RTL of the block; a class holds the batch and its expected sorted order.
module hybrid_merge_insertion_sorter_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 400000;
	localparam int ITEM_BUDGET = 280;
	localparam int SETTLE_CYCLES = 300;

	typedef struct packed {
		logic signed [hms_pkg::DATA_W-1:0] value;
		logic                              last_flag;
		logic                              ovf;
	} sorted_beat_t;

	typedef enum {
		FILL_SCATTER,
		FILL_NARROW,
		FILL_RISING,
		FILL_FALLING,
		FILL_EXTREME
	} fill_kind_t;

	// Collects the open batch and queues its values in ascending order when it closes.
	class sorted_batch_board;
		logic signed [hms_pkg::DATA_W-1:0] batch[$];
		bit                                dropped;
		sorted_beat_t                      sorted_pending[$];
		int                                mismatches;

		function void note_beat(logic signed [hms_pkg::DATA_W-1:0] v, logic lst);
			logic signed [hms_pkg::DATA_W-1:0] held;
			int j;
			sorted_beat_t beat;
			// keep the beat while there is room, otherwise flag the batch
			if (batch.size() < hms_pkg::MAX_ITEMS) begin
				batch.push_back(v);
			end else begin
				dropped = 1'b1;
			end
			if (!lst) begin
				return;
			end
			// order the held values; ties are indistinguishable
			for (int i = 1; i < batch.size(); i++) begin
				held = batch[i];
				j = i;
				while (j > 0 && held < batch[j-1]) begin
					batch[j] = batch[j-1];
					j--;
				end
				batch[j] = held;
			end
			foreach (batch[k]) begin
				beat.value = batch[k];
				beat.last_flag = (k == batch.size() - 1);
				beat.ovf = dropped;
				sorted_pending.push_back(beat);
			end
			batch.delete();
			dropped = 1'b0;
		endfunction

		function void check_result(logic signed [hms_pkg::DATA_W-1:0] v, logic lst, logic ovf);
			sorted_beat_t want;
			if (sorted_pending.size() == 0) begin
				$error("unexpected result beat: sorted_value=%0d last_out=%0b overflow=%0b",
					v, lst, ovf);
				mismatches++;
				return;
			end
			want = sorted_pending.pop_front();
			if (v !== want.value) begin
				$error("sorted_value: expected %0d, actual %0d", want.value, v);
				mismatches++;
			end
			if (lst !== want.last_flag) begin
				$error("last_out: expected %0b, actual %0b", want.last_flag, lst);
				mismatches++;
			end
			if (ovf !== want.ovf) begin
				$error("overflow: expected %0b, actual %0b", want.ovf, ovf);
				mismatches++;
			end
		endfunction

		function int pending();
			return sorted_pending.size();
		endfunction
	endclass

	logic                              clk = 1'b0;
	logic                              arst_n = 1'b0;
	logic                              in_valid = 1'b0;
	logic                              in_stall;
	logic signed [hms_pkg::DATA_W-1:0] value = '0;
	logic                              last_item = 1'b0;
	logic                              out_valid;
	logic                              out_stall = 1'b0;
	logic signed [hms_pkg::DATA_W-1:0] sorted_value;
	logic                              last_out;
	logic                              overflow;

	sorted_batch_board board = new;
	int                cycles = 0;
	int                hold_left = 0;
	int                free_left = 0;

	hybrid_merge_insertion_sorter DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.value(value),
		.last_item(last_item),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.sorted_value(sorted_value),
		.last_out(last_out),
		.overflow(overflow)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Mostly short gaps, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) begin
			return 0;
		end else if (r < 85) begin
			return $urandom_range(1, 3);
		end else if (r < 97) begin
			return $urandom_range(4, 10);
		end
		return $urandom_range(20, 60);
	endfunction

	// Abort a hung run.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// Check every result beat taken by the sink.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			board.check_result(sorted_value, last_out, overflow);
		end
	end

	// Stall the result side in bursts, with free-running stretches between.
	always @(negedge clk) begin
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left--;
		end else if (free_left > 0) begin
			out_stall <= 1'b0;
			free_left--;
		end else begin
			out_stall <= 1'b0;
			free_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80)
				: $urandom_range(0, 6);
			hold_left = pick_gap();
		end
	end

	// Present one beat, hold it until taken, then idle for a random gap, which may be zero.
	task automatic send_beat(input logic signed [hms_pkg::DATA_W-1:0] v, input logic lst,
			input bit quiet);
		int gap;
		in_valid <= 1'b1;
		value <= v;
		last_item <= lst;
		do @(posedge clk); while (in_stall);
		board.note_beat(v, lst);
		@(negedge clk);
		gap = quiet ? 0 : pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	task automatic send_batch(input int len, input fill_kind_t kind);
		logic signed [hms_pkg::DATA_W-1:0] start;
		logic signed [hms_pkg::DATA_W-1:0] v;
		bit quiet;
		start = $urandom;
		quiet = ($urandom_range(0, 4) == 0);
		for (int i = 0; i < len; i++) begin
			case (kind)
				FILL_SCATTER: v = $urandom;
				FILL_NARROW: v = $urandom_range(0, 16) - 8;
				FILL_RISING: v = start + 3 * i;
				FILL_FALLING: v = start - 5 * i;
				default: begin
					case ($urandom_range(0, 3))
						0: v = 32'sh7fffffff;
						1: v = 32'sh80000000;
						2: v = '0;
						default: v = -1;
					endcase
				end
			endcase
			send_beat(v, i == len - 1, quiet);
		end
	endtask

	task automatic wait_drained();
		while (board.pending() != 0) @(posedge clk);
	endtask

	initial begin
		logic signed [hms_pkg::DATA_W-1:0] mixed [10];
		int sent;
		int len;
		int fixed_len [4];
		fill_kind_t kind;

		mixed = '{0, -1, 1, 32'sh80000000, 32'sh7fffffff, -1, 0, 32'sh40000000,
			32'shbfffffff, 5};
		fixed_len = '{26, 27, hms_pkg::MAX_ITEMS, hms_pkg::MAX_ITEMS + 1};
		sent = 0;

		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// single value, reversed pair of extremes, mixed signs with ties, all equal
		send_beat(32'sh7fffffff, 1'b1, 1'b0);
		send_beat(32'sh7fffffff, 1'b0, 1'b0);
		send_beat(32'sh80000000, 1'b1, 1'b0);
		foreach (mixed[i]) begin
			send_beat(mixed[i], i == 9, 1'b0);
		end
		for (int i = 0; i < 5; i++) begin
			send_beat(32'sha5a5a5a5, i == 4, 1'b0);
		end

		// hold the sender until every directed result has come back
		in_valid <= 1'b0;
		wait_drained();
		@(negedge clk);

		// sizes 26 and 27, a full store, a store overrun, then random
		while (sent < ITEM_BUDGET) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3: kind = FILL_SCATTER;
				4, 5: kind = FILL_NARROW;
				6: kind = FILL_RISING;
				7: kind = FILL_FALLING;
				default: kind = FILL_EXTREME;
			endcase
			if (sent < 26 + 27 + hms_pkg::MAX_ITEMS + hms_pkg::MAX_ITEMS + 1) begin
				if (sent < 26) len = fixed_len[0];
				else if (sent < 26 + 27) len = fixed_len[1];
				else if (sent < 26 + 27 + hms_pkg::MAX_ITEMS) len = fixed_len[2];
				else len = fixed_len[3];
			end else begin
				case ($urandom_range(0, 19))
					0: len = $urandom_range(hms_pkg::MAX_ITEMS + 1, hms_pkg::MAX_ITEMS + 6);
					1, 2: len = $urandom_range(27, hms_pkg::MAX_ITEMS);
					default: len = $urandom_range(1, 26);
				endcase
			end
			send_batch(len, kind);
			sent += len;
		end

		// drain, then make sure nothing further comes out
		in_valid <= 1'b0;
		last_item <= 1'b0;
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (board.pending() != 0) begin
			$error("%0d expected result beats never arrived", board.pending());
		end
		if (board.mismatches == 0 && board.pending() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
